/* rtl/lbcd_pkg.sv */
// Package with the opcodes, status codes and the cell interface types of the directory.
`default_nettype none
package lbcd_pkg;
    localparam int SLOTS    = 128;
    localparam int DISKS    = 8;
    localparam int REF_BITS = 8;
    localparam int SLOT_W   = 7;
    localparam int SEC_W    = 32;
    localparam int DISK_W   = 3;

    localparam logic [2:0] OP_ACQUIRE     = 3'd0;
    localparam logic [2:0] OP_RELEASE     = 3'd1;
    localparam logic [2:0] OP_FILL_OK     = 3'd2;
    localparam logic [2:0] OP_FILL_FAILED = 3'd3;
    localparam logic [2:0] OP_MARK_DIRTY  = 3'd4;
    localparam logic [2:0] OP_MARK_CLEAN  = 3'd5;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_PENDING  = 3'd2;
    localparam logic [2:0] ST_NOVICTIM = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;

    // Contents of one rank of the recency chain.
    typedef struct packed {
        logic [SLOT_W-1:0]   id;
        logic                valid;
        logic [DISK_W-1:0]   disk;
        logic [SEC_W-1:0]    sector;
        logic [REF_BITS-1:0] refs;
        logic                dirty;
        logic                pending;
    } t_entry;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic              lookup;
        logic [DISK_W-1:0] disk;
        logic [SEC_W-1:0]  sector;
        logic              apply;
        logic [2:0]        op;
        logic              to_front;
        logic [SLOT_W-1:0] slot;
    } t_cmd;
endpackage
`default_nettype wire

/* rtl/lbcd_cell.sv */
// One rank of the recency chain: holds a slot's entry and shifts toward the older side.
`default_nettype none
module lbcd_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [6:0]     i_reset_id,
    input  wire lbcd_pkg::t_cmd i_cmd,
    input  wire lbcd_pkg::t_entry i_prev,
    input  wire logic           i_shift_in,
    output lbcd_pkg::t_entry    o_entry,
    output logic                o_hit,
    output logic                o_sel,
    output logic                o_shift_out
);
    lbcd_pkg::t_entry r_e, n_e, upd;
    logic sel;

    assign sel = (r_e.id == i_cmd.slot);
    assign o_sel = sel;
    assign o_hit = r_e.valid && r_e.disk == i_cmd.disk && r_e.sector == i_cmd.sector;
    // The shift request comes from the older neighbor: a cell moves when it or any older
    // cell holds the target, so every rank from zero down to the target slides one step.
    assign o_shift_out = i_shift_in | sel;
    assign o_entry = r_e;

    always_comb begin
        upd = r_e;
        case (i_cmd.op)
            lbcd_pkg::OP_ACQUIRE: begin
                if (r_e.valid && !r_e.pending &&
                    r_e.disk == i_cmd.disk && r_e.sector == i_cmd.sector) begin
                    upd.refs = r_e.refs + (lbcd_pkg::REF_BITS)'(1);
                end else begin
                    upd.valid   = 1'b1;
                    upd.disk    = i_cmd.disk;
                    upd.sector  = i_cmd.sector;
                    upd.refs    = {{(lbcd_pkg::REF_BITS-1){1'b0}}, 1'b1};
                    upd.pending = 1'b1;
                end
            end
            lbcd_pkg::OP_RELEASE: upd.refs = r_e.refs - (lbcd_pkg::REF_BITS)'(1);
            lbcd_pkg::OP_FILL_OK: upd.pending = 1'b0;
            lbcd_pkg::OP_FILL_FAILED: begin
                upd.pending = 1'b0;
                upd.valid   = 1'b0;
                upd.dirty   = 1'b0;
                if (r_e.refs != '0) upd.refs = r_e.refs - (lbcd_pkg::REF_BITS)'(1);
            end
            lbcd_pkg::OP_MARK_DIRTY: upd.dirty = 1'b1;
            lbcd_pkg::OP_MARK_CLEAN: upd.dirty = 1'b0;
            default: ;
        endcase
    end

    always_comb begin
        n_e = r_e;
        if (i_cmd.apply) begin
            if (i_cmd.to_front && (i_shift_in || sel)) n_e = i_prev;
            else if (sel) n_e = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.id      <= i_reset_id;
            r_e.valid   <= 1'b0;
            r_e.refs    <= '0;
            r_e.dirty   <= 1'b0;
            r_e.pending <= 1'b0;
        end else begin
            r_e <= n_e;
        end
    end
endmodule
`default_nettype wire

/* rtl/lru_block_cache_directory_unit.sv */
// Top level of the LRU block cache directory: controller around a chain of slot cells.
//
// Input items (op, disk, sector, slot) arrive on i_valid / o_stall; result items
// (status, granted slot, now_free) leave on o_valid / i_stall. Each item makes one
// result. An item runs as a search and then an update: first the tag is compared in
// every cell at once and the victim is found; then the command is broadcast and,
// for a granted acquire, the chain shifts the touched entry to rank zero, updating it
// on the way; other ops update the selected entry in place. The input stays closed
// while an item is in flight and opens only when its update is done.
// Results sit in an output register; the next item is taken while a result waits,
// but its result stalls the block until the register is free.
// Reset is synchronous, active low: all slots invalid with no references, slot i at
// rank i. A stalled result holds its value until taken.
`default_nettype none
module lru_block_cache_directory_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [2:0]  i_disk_id,
    input  wire logic [31:0] i_sector,
    input  wire logic [6:0]  i_slot,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [6:0]       o_granted_slot,
    output logic             o_now_free
);
    localparam int N = lbcd_pkg::SLOTS;

    lbcd_pkg::t_entry ent [N];
    logic [N-1:0] hit, sel, shin, shout;
    lbcd_pkg::t_cmd cmd;
    lbcd_pkg::t_entry front;

    logic       r_busy;
    logic [2:0] r_op;
    logic [2:0] r_disk;
    logic [31:0] r_sector;
    logic [6:0] r_slot;

    // The shift request ripples from the oldest rank toward rank zero, so every rank
    // at or newer than the target moves; rank zero takes the updated target entry.
    assign shin[N-1] = 1'b0;
    for (genvar g = 0; g < N-1; g++) begin : g_sh
        assign shin[g] = shout[g+1];
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        lbcd_pkg::t_entry prev;
        if (g == 0) begin : g_f
            assign prev = front;
        end else begin : g_o
            assign prev = ent[g-1];
        end
        lbcd_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_reset_id(7'(g)), .i_cmd(cmd),
            .i_prev(prev), .i_shift_in(shin[g]), .o_entry(ent[g]),
            .o_hit(hit[g]), .o_sel(sel[g]), .o_shift_out(shout[g])
        );
    end

    // Search results: hit rank and oldest free victim rank.
    logic       any_hit, any_vic;
    logic [6:0] hit_rank, vic_rank;
    always_comb begin
        any_hit = 1'b0; hit_rank = '0; any_vic = 1'b0; vic_rank = '0;
        for (int k = N-1; k >= 0; k--) begin
            if (hit[k]) begin any_hit = 1'b1; hit_rank = 7'(k); end
        end
        for (int k = 0; k < N; k++) begin
            if (ent[k].refs == '0 && !ent[k].dirty) begin
                any_vic = 1'b1; vic_rank = 7'(k);
            end
        end
    end

    // Registered search results, captured in the search phase.
    logic r_phase;
    logic r_any_hit, r_any_vic;
    logic [6:0] r_hit_rank, r_vic_rank;

    lbcd_pkg::t_entry tgt, upd_front;
    logic [2:0] st;
    logic [6:0] gs;
    logic nf, doit, front_op;
    logic [6:0] tslot;

    always_comb begin
        st = lbcd_pkg::ST_ERROR; gs = r_slot; nf = 1'b0; doit = 1'b0; front_op = 1'b0;
        tslot = r_slot;
        tgt = ent[r_slot];
        if (r_op == lbcd_pkg::OP_ACQUIRE) begin
            gs = '0;
            if (r_disk >= 3'(lbcd_pkg::DISKS - 1) + 3'd1 && lbcd_pkg::DISKS < 8) begin
                st = lbcd_pkg::ST_ERROR;
            end else if (r_any_hit) begin
                tgt = ent[r_hit_rank]; gs = tgt.id; tslot = tgt.id;
                if (tgt.pending) st = lbcd_pkg::ST_PENDING;
                else if (tgt.refs == '1) st = lbcd_pkg::ST_ERROR;
                else begin st = lbcd_pkg::ST_HIT; doit = 1'b1; front_op = 1'b1; end
            end else if (r_any_vic) begin
                tgt = ent[r_vic_rank]; gs = tgt.id; tslot = tgt.id;
                st = lbcd_pkg::ST_MISS; doit = 1'b1; front_op = 1'b1;
            end else begin
                st = lbcd_pkg::ST_NOVICTIM;
            end
        end else begin
            // Locate slot by id among ranks.
            for (int k = 0; k < N; k++) if (ent[k].id == r_slot) tgt = ent[k];
            case (r_op)
                lbcd_pkg::OP_RELEASE: if (tgt.refs != '0) begin
                    st = lbcd_pkg::ST_DONE; doit = 1'b1;
                    nf = (tgt.refs == (lbcd_pkg::REF_BITS)'(1));
                end
                lbcd_pkg::OP_FILL_OK: if (tgt.pending) begin
                    st = lbcd_pkg::ST_DONE; doit = 1'b1;
                end
                lbcd_pkg::OP_FILL_FAILED: if (tgt.pending) begin
                    st = lbcd_pkg::ST_DONE; doit = 1'b1;
                    nf = (tgt.refs == (lbcd_pkg::REF_BITS)'(1));
                end
                lbcd_pkg::OP_MARK_DIRTY: if (tgt.valid) begin
                    st = lbcd_pkg::ST_DONE; doit = 1'b1;
                end
                lbcd_pkg::OP_MARK_CLEAN: begin st = lbcd_pkg::ST_DONE; doit = 1'b1; end
                default: ;
            endcase
        end
        // Front entry after update, for an acquire that moves to rank zero.
        upd_front = tgt;
        if (r_any_hit) upd_front.refs = tgt.refs + (lbcd_pkg::REF_BITS)'(1);
        else begin
            upd_front.valid = 1'b1; upd_front.disk = r_disk; upd_front.sector = r_sector;
            upd_front.refs = (lbcd_pkg::REF_BITS)'(1); upd_front.pending = 1'b1;
        end
    end

    assign front = upd_front;
    assign cmd.lookup   = 1'b0;
    assign cmd.disk     = r_disk;
    assign cmd.sector   = r_sector;
    assign cmd.apply    = r_busy && r_phase && !(o_valid && i_stall) && doit;
    assign cmd.op       = r_op;
    assign cmd.to_front = front_op;
    assign cmd.slot     = tslot;

    logic done2;
    assign done2 = r_busy && r_phase && !(o_valid && i_stall);
    assign o_stall = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_phase <= 1'b0; o_valid <= 1'b0;
        end else begin
            if (!r_busy && i_valid) begin
                r_busy <= 1'b1; r_phase <= 1'b0;
                r_op <= i_op; r_disk <= i_disk_id; r_sector <= i_sector; r_slot <= i_slot;
            end else if (r_busy && !r_phase) begin
                r_phase <= 1'b1;
                r_any_hit <= any_hit; r_any_vic <= any_vic;
                r_hit_rank <= hit_rank; r_vic_rank <= vic_rank;
            end else if (done2) begin
                r_busy <= 1'b0; r_phase <= 1'b0;
                o_valid <= 1'b1; o_status <= st; o_granted_slot <= gs; o_now_free <= nf;
            end
            // A taken result empties the register unless a new one lands in it.
            if (o_valid && !i_stall && !done2) o_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire
